>>> sv/sitd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared definitions
// Widths, digit counts, character codes and the stage payload type.
// ----------------------------------------------------------------------------
package sitd_pkg;

  localparam int DATA_BITS  = 32;
  // Number of decimal digits of 2^(DATA_BITS-1), from log10(2) ~ 0.30103.
  localparam int NUM_DIGITS = ((DATA_BITS - 1) * 30103) / 100000 + 1;
  localparam int STEP_BITS  = 8;
  localparam int NUM_STAGES = (DATA_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS   = NUM_STAGES * STEP_BITS;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic                           neg;
    digit_t [NUM_DIGITS-1:0]        bcd;
    logic   [PAD_BITS-1:0]          bin;
  } dab_t;

endpackage

>>> sv/sitd_dabble_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: conversion stage
// One registered stage of the binary to BCD conversion, shifting in
// STEP_BITS bits of the magnitude with add-three correction.
// ----------------------------------------------------------------------------
module sitd_dabble_stage
  import sitd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  dab_t in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output dab_t out_data_o,
  input  logic out_ready_i
);

  dab_t work;
  logic valid_q;
  dab_t data_q;

  always_comb begin
    work = in_data_i;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work.bcd[d] >= 4'd5) begin
          work.bcd[d] = work.bcd[d] + 4'd3;
        end
      end
      {work.bcd, work.bin} = {work.bcd, work.bin} << 1;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= work;
    end
  end

endmodule

>>> sv/sitd_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: character serializer
// Holds one converted number and emits its sign and significant digits as
// ASCII, one character per cycle unless stalled, flagging the final one.
// ----------------------------------------------------------------------------
module sitd_serializer
  import sitd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dab_t       in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] character_o,
  output logic       last_o
);

  logic                    busy_q;
  logic                    sign_q;
  logic [DIG_IDX_W-1:0]    idx_q;
  digit_t [NUM_DIGITS-1:0] digits_q;
  logic [DIG_IDX_W-1:0]    top_idx;
  logic                    last;
  logic                    fire;
  logic                    load;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_data_i.bcd[i] != 4'd0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end
  end

  assign last       = !sign_q && (idx_q == '0);
  assign fire       = busy_q && !out_stall_i;
  assign in_ready_o = !busy_q || (fire && last);
  assign load       = in_valid_i && in_ready_o;

  assign out_valid_o = busy_q;
  assign last_o      = last;
  assign character_o = sign_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits_q[idx_q]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      sign_q <= in_data_i.neg;
      idx_q  <= top_idx;
    end else if (fire) begin
      if (last) begin
        busy_q <= 1'b0;
      end else if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= in_data_i.bcd;
    end
  end

  // A request with more characters to go keeps the output valid.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last) |=> busy_q)
    else $error("output dropped before the final character");

  // A negative number always starts with the minus sign.
  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_data_i.neg) |=> (out_valid_o && character_o == CHAR_MINUS))
    else $error("negative number does not start with a minus sign");

  // Every digit shown is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !sign_q) |-> (digits_q[idx_q] <= 4'd9))
    else $error("digit out of decimal range");

  // A pending sign only exists inside an active run.
  a_sign_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q |-> busy_q)
    else $error("sign pending while idle");

endmodule

>>> sv/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// The first character follows the input register, the four conversion stages
//   and then the serializer load, each registered.
// New numbers enter conversion while the serializer still sends earlier ones. It
//   sends one character per cycle unless stalled, 1 to 11 per number at 32 bits.
// Reset clears all valid flags and the serializer; no state is kept between numbers.
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII
// Converts a two's-complement integer into its decimal ASCII text through a
// pipelined binary to BCD converter followed by a character serializer.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sitd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DATA_BITS-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           character_o,
  output logic                 last_o
);

  logic [NUM_STAGES:0]  stg_valid;
  logic [NUM_STAGES:0]  stg_ready;
  dab_t                 stg_data [NUM_STAGES+1];
  logic                 in_ready;
  logic                 in_neg;
  logic [DATA_BITS-1:0] in_mag;
  logic                 in_valid_q;
  dab_t                 in_data_q;
  dab_t                 ser_data;
  logic                 ser_valid;
  logic                 ser_ready;

  assign in_neg     = value_i[DATA_BITS-1];
  assign in_mag     = in_neg ? (~value_i + 1'b1) : value_i;
  assign in_ready   = !in_valid_q || stg_ready[0];
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_data_q.neg <= in_neg;
      in_data_q.bcd <= '0;
      in_data_q.bin <= PAD_BITS'(in_mag);
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_data[0]  = in_data_q;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sitd_dabble_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g]),
      .in_data_i   (stg_data[g]),
      .in_ready_o  (stg_ready[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_data_o  (stg_data[g+1]),
      .out_ready_i (stg_ready[g+1])
    );
  end

  assign ser_valid             = stg_valid[NUM_STAGES];
  assign ser_data              = stg_data[NUM_STAGES];
  assign stg_ready[NUM_STAGES] = ser_ready;

  sitd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ser_valid),
    .in_data_i   (ser_data),
    .in_ready_o  (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII converter
// A scoreboard predicts the character text of every accepted request and
// checks each character that leaves the block. Directed extremes are followed
// by random numbers of every length, under several idle and stall phases and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sitd_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 25;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending_text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void add_number_text(logic [DATA_BITS-1:0] num);
      logic             neg;
      logic [DATA_BITS:0] mag;
      logic [3:0]       digits[$];
      text_char_t       ch;
      neg = num[DATA_BITS-1];
      mag = neg ? ({1'b0, ~num} + 1'b1) : {1'b0, num};
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        ch.code = CHAR_MINUS;
        ch.last = 1'b0;
        pending_text.push_back(ch);
      end
      for (int k = 0; k < digits.size(); k++) begin
        ch.code = CHAR_ZERO + 8'(digits[k]);
        ch.last = (k == digits.size() - 1);
        pending_text.push_back(ch);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t exp_ch;
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character %0d last %0b", $time, code, last);
        errors++;
        return;
      end
      exp_ch = pending_text.pop_front();
      if (code !== exp_ch.code) begin
        $display("%0t: character expected %0d actual %0d", $time, exp_ch.code, code);
        errors++;
      end
      if (last !== exp_ch.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_ch.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [DATA_BITS-1:0] value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           character_o;
  logic                 last_o;

  text_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_req = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int             cycle_count = 0;

  signed_int_to_decimal_ascii i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.add_number_text(value_i);
      if (out_valid_o && !out_stall_i) sb.check_char(character_o, last_o);
    end
  end

  // The output side stalls at random, or for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_number(input logic [DATA_BITS-1:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [DATA_BITS-1:0] random_number();
    logic [DATA_BITS-1:0] num;
    num = $urandom;
    if ($urandom_range(3) != 0) num = num >> $urandom_range(DATA_BITS - 1);
    if ($urandom_range(1) != 0) num = -num;
    return num;
  endfunction

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_number(random_number());
  endtask

  initial begin
    logic [DATA_BITS-1:0] directed[$];
    int                   drain;
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd100, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
                 32'h5555_5555, 32'haaaa_aaaa, 32'd147483648, -32'sd147483648};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_number(directed[i]);

    hold_req = hold_req + 1;
    run_random_phase(0, 0);
    run_random_phase(63, 0);
    run_random_phase(0, 63);
    run_random_phase(10, 10);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (sb.pending_text.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_text.size() == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
